/* rtl/core/drs_pkg.sv */
// Package for the dynamic resolution scaler: field widths, reset values,
// register indexes, arithmetic constants and the controller-to-datapath command.
// No dependencies.
package drs_pkg;

  // Field widths
  localparam int unsigned TimeW    = 16;
  localparam int unsigned ElapsedW = 20;
  localparam int unsigned ScaleW   = 7;
  localparam int unsigned DimW     = 14;
  localparam int unsigned AlphaW   = 9;
  localparam int unsigned CountW   = 27;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Derived widths
  localparam int unsigned ThreshW  = 23;  // 16-bit time times 100
  localparam int unsigned CoolW    = 26;  // 16-bit ms times 1000
  localparam int unsigned MulAW    = 21;
  localparam int unsigned MulBW    = 22;
  localparam int unsigned ProdW    = MulAW + MulBW;
  localparam int unsigned AccW     = 24;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_ENABLE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TARGET   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ALPHA    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MIN      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MAX      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_COOLDOWN = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_NATIVE_W = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_NATIVE_H = 3'd7;

  // Register reset values
  localparam logic              ENABLE_RST   = 1'b1;
  localparam logic [TimeW-1:0]  TARGET_RST   = 16'd4267;
  localparam logic [AlphaW-1:0] ALPHA_RST    = 9'd26;
  localparam logic [ScaleW-1:0] MIN_RST      = 7'd50;
  localparam logic [ScaleW-1:0] MAX_RST      = 7'd100;
  localparam logic [TimeW-1:0]  COOLDOWN_RST = 16'd500;
  localparam logic [DimW-1:0]   NATIVE_W_RST = 14'd1920;
  localparam logic [DimW-1:0]   NATIVE_H_RST = 14'd1080;

  // Arithmetic constants
  localparam int unsigned DEFAULT_MAX_DIMENSION = 8192;
  localparam logic [ThreshW-1:0] PERCENT_ONE   = 23'd100;
  localparam logic [ThreshW-1:0] DOWN_FACTOR   = 23'd92;
  localparam logic [ThreshW-1:0] UP_FACTOR     = 23'd75;
  localparam logic [CoolW-1:0]   US_PER_MS     = 26'd1000;
  localparam logic [ScaleW-1:0]  SCALE_STEP    = 7'd5;
  localparam logic [ScaleW-1:0]  SCALE_FULL    = 7'd100;
  localparam logic [AlphaW-1:0]  ALPHA_ONE     = 9'd256;
  localparam logic [CountW-1:0]  COUNT_MAX     = 27'h7FF_FFFF;
  // floor(x/100) == (x * DIV100_RECIP) >> DIV100_SHIFT for every x below 2^21
  localparam logic [MulBW-1:0]   DIV100_RECIP  = 22'd2684355;
  localparam int unsigned        DIV100_SHIFT  = 28;

  localparam logic [ThreshW-1:0] DOWN_RST = ThreshW'(TARGET_RST * DOWN_FACTOR);
  localparam logic [ThreshW-1:0] UP_RST   = ThreshW'(TARGET_RST * UP_FACTOR);
  localparam logic [CoolW-1:0]   COOL_RST = CoolW'(COOLDOWN_RST * US_PER_MS);

  // Datapath operations, one per controller step
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_AVG_MUL,
    OP_AVG_ADD,
    OP_DECIDE,
    OP_W_MUL,
    OP_W_DIV,
    OP_H_MUL,
    OP_H_DIV
  } drs_op_e;

  typedef struct packed {
    drs_op_e op;
    logic    capture;   // latch the input item
    logic    load_out;  // move the finished result into the output register
  } drs_cmd_t;

endpackage

/* rtl/core/drs_if.sv */
// Valid/ready channel interfaces for the dynamic resolution scaler items.
// Depends on drs_pkg for field widths.
interface drs_in_if;
  logic                          valid;
  logic                          ready;
  logic [drs_pkg::TimeW-1:0]     frame_time;
  logic [drs_pkg::ElapsedW-1:0]  elapsed_us;

  modport source (output valid, frame_time, elapsed_us, input ready);
  modport sink   (input valid, frame_time, elapsed_us, output ready);
endinterface

interface drs_out_if;
  logic                        valid;
  logic                        ready;
  logic [drs_pkg::ScaleW-1:0]  scale_percent;
  logic [drs_pkg::DimW-1:0]    render_width;
  logic [drs_pkg::DimW-1:0]    render_height;
  logic [drs_pkg::TimeW-1:0]   average_frame_time;

  modport source (output valid, scale_percent, render_width, render_height,
                  average_frame_time, input ready);
  modport sink   (input valid, scale_percent, render_width, render_height,
                  average_frame_time, output ready);
endinterface

/* rtl/core/drs_ctrl.sv */
// Sequencing controller for the dynamic resolution scaler.
// Depends on drs_pkg; drives the command struct of drs_datapath.
module drs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output drs_pkg::drs_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_AVG_MUL,
    S_AVG_ADD,
    S_DECIDE,
    S_W_MUL,
    S_W_DIV,
    S_H_MUL,
    S_H_DIV,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   load_out;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign load_out    = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE:    if (accept) state_d = S_AVG_MUL;
      S_AVG_MUL: state_d = S_AVG_ADD;
      S_AVG_ADD: state_d = S_DECIDE;
      S_DECIDE:  state_d = S_W_MUL;
      S_W_MUL:   state_d = S_W_DIV;
      S_W_DIV:   state_d = S_H_MUL;
      S_H_MUL:   state_d = S_H_DIV;
      S_H_DIV:   state_d = S_FINISH;
      S_FINISH: begin
        // hold until the output register is free
        if (load_out) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.capture  = accept;
    cmd_o.load_out = load_out;
    case (state_q)
      S_AVG_MUL: cmd_o.op = drs_pkg::OP_AVG_MUL;
      S_AVG_ADD: cmd_o.op = drs_pkg::OP_AVG_ADD;
      S_DECIDE:  cmd_o.op = drs_pkg::OP_DECIDE;
      S_W_MUL:   cmd_o.op = drs_pkg::OP_W_MUL;
      S_W_DIV:   cmd_o.op = drs_pkg::OP_W_DIV;
      S_H_MUL:   cmd_o.op = drs_pkg::OP_H_MUL;
      S_H_DIV:   cmd_o.op = drs_pkg::OP_H_DIV;
      default:   cmd_o.op = drs_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_AVG_MUL)
    else $error("accepted item did not start the average step");

  a_avg_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_AVG_MUL |=> state_q == S_AVG_ADD ##1 state_q == S_DECIDE)
    else $error("average steps out of order");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q && state_q == S_IDLE)
    else $error("loaded result not presented");

endmodule

/* rtl/core/drs_datapath.sv */
// Datapath for the dynamic resolution scaler: configuration registers, state,
// one shared multiplier and the output register. Depends on drs_pkg.
module drs_datapath #(
  parameter int unsigned MaxDimension = drs_pkg::DEFAULT_MAX_DIMENSION
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  drs_pkg::drs_cmd_t              cmd_i,
  input  logic                           cfg_we_i,
  input  logic [drs_pkg::CfgIdxW-1:0]    cfg_addr_i,
  input  logic [drs_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic [drs_pkg::TimeW-1:0]      frame_time_i,
  input  logic [drs_pkg::ElapsedW-1:0]   elapsed_us_i,
  output logic [drs_pkg::ScaleW-1:0]     scale_percent_o,
  output logic [drs_pkg::DimW-1:0]       render_width_o,
  output logic [drs_pkg::DimW-1:0]       render_height_o,
  output logic [drs_pkg::TimeW-1:0]      average_frame_time_o
);

  localparam int unsigned DimXW = drs_pkg::DimW + 1;
  localparam logic [DimXW-1:0] DimCap = DimXW'(MaxDimension);

  // Configuration
  logic                           en_q;
  logic [drs_pkg::AlphaW-1:0]     alpha_q;
  logic [drs_pkg::ScaleW-1:0]     min_q, max_q;
  logic [drs_pkg::ThreshW-1:0]    down_thr_q, up_thr_q;
  logic [drs_pkg::CoolW-1:0]      cool_us_q;
  logic [drs_pkg::DimW-1:0]       nw_q, nh_q;

  // State and work registers
  logic [drs_pkg::TimeW-1:0]      st_q, st_d;
  logic [drs_pkg::ScaleW-1:0]     scale_q, scale_d;
  logic [drs_pkg::CountW-1:0]     since_q, since_d;
  logic [drs_pkg::TimeW-1:0]      ft_q;
  logic [drs_pkg::ElapsedW-1:0]   el_q;
  logic [drs_pkg::AccW-1:0]       acc_q, acc_d;
  logic [drs_pkg::DimW-1:0]       w_q, w_d, h_q, h_d;

  // Output register
  logic [drs_pkg::ScaleW-1:0]     res_scale_q;
  logic [drs_pkg::DimW-1:0]       res_w_q, res_h_q;
  logic [drs_pkg::TimeW-1:0]      res_avg_q;

  logic [drs_pkg::AlphaW-1:0]     alpha_sat;
  logic [drs_pkg::ScaleW-1:0]     lo, hi;
  logic [drs_pkg::MulAW-1:0]      mul_a;
  logic [drs_pkg::MulBW-1:0]      mul_b;
  logic [drs_pkg::ProdW-1:0]      prod;
  logic [drs_pkg::AccW:0]         avg_sum;
  logic [drs_pkg::CountW:0]       since_sum;
  logic [drs_pkg::ThreshW-1:0]    avg100;
  logic [drs_pkg::DimW-1:0]       quot;
  logic [DimXW-1:0]               w_round, h_round;
  logic [drs_pkg::ScaleW-1:0]     dn_scale, up_scale, next_scale;
  logic [drs_pkg::ScaleW:0]       up_raw;
  logic                           step_dn, step_up;

  function automatic logic [drs_pkg::DimW-1:0] clamp_dim(input logic [DimXW-1:0] v);
    logic [DimXW-1:0] c;
    c = (v > DimCap) ? DimCap : v;
    return c[drs_pkg::DimW-1:0];
  endfunction

  assign alpha_sat = (alpha_q > drs_pkg::ALPHA_ONE) ? drs_pkg::ALPHA_ONE : alpha_q;
  assign lo = (min_q > drs_pkg::SCALE_FULL) ? drs_pkg::SCALE_FULL : min_q;
  assign hi = (max_q > drs_pkg::SCALE_FULL) ? drs_pkg::SCALE_FULL : max_q;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      drs_pkg::OP_AVG_MUL: begin
        mul_a = drs_pkg::MulAW'(st_q);
        mul_b = drs_pkg::MulBW'(drs_pkg::ALPHA_ONE - alpha_sat);
      end
      drs_pkg::OP_AVG_ADD: begin
        mul_a = drs_pkg::MulAW'(ft_q);
        mul_b = drs_pkg::MulBW'(alpha_sat);
      end
      drs_pkg::OP_W_MUL: begin
        mul_a = drs_pkg::MulAW'(nw_q);
        mul_b = drs_pkg::MulBW'(scale_q);
      end
      drs_pkg::OP_H_MUL: begin
        mul_a = drs_pkg::MulAW'(nh_q);
        mul_b = drs_pkg::MulBW'(scale_q);
      end
      drs_pkg::OP_W_DIV, drs_pkg::OP_H_DIV: begin
        mul_a = acc_q[drs_pkg::MulAW-1:0];
        mul_b = drs_pkg::DIV100_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod      = drs_pkg::ProdW'(mul_a) * drs_pkg::ProdW'(mul_b);
  assign avg_sum   = {1'b0, acc_q} + (drs_pkg::AccW + 1)'(prod[drs_pkg::AccW-1:0]);
  assign since_sum = {1'b0, since_q} + (drs_pkg::CountW + 1)'(el_q);
  assign avg100    = drs_pkg::ThreshW'(st_q) * drs_pkg::PERCENT_ONE;
  assign quot      = prod[drs_pkg::DIV100_SHIFT +: drs_pkg::DimW];
  assign w_round   = (DimXW'(quot) + DimXW'(15)) & ~DimXW'(15);
  assign h_round   = (DimXW'(quot) + DimXW'(1)) & ~DimXW'(1);

  // Scale decision
  assign step_dn  = avg100 > down_thr_q;
  assign step_up  = (avg100 < up_thr_q) &&
                    (drs_pkg::CountW'(cool_us_q) <= since_q);
  assign dn_scale = (scale_q >= drs_pkg::SCALE_STEP) ?
                    ((scale_q - drs_pkg::SCALE_STEP > lo) ? scale_q - drs_pkg::SCALE_STEP : lo)
                    : lo;
  assign up_raw   = {1'b0, scale_q} + {1'b0, drs_pkg::SCALE_STEP};
  assign up_scale = (up_raw < {1'b0, hi}) ? up_raw[drs_pkg::ScaleW-1:0] : hi;

  always_comb begin
    next_scale = scale_q;
    if (step_dn) begin
      next_scale = dn_scale;
    end else if (step_up) begin
      next_scale = up_scale;
    end
  end

  always_comb begin
    st_d    = st_q;
    scale_d = scale_q;
    since_d = since_q;
    acc_d   = acc_q;
    w_d     = w_q;
    h_d     = h_q;
    case (cmd_i.op)
      drs_pkg::OP_AVG_MUL: acc_d = prod[drs_pkg::AccW-1:0];
      drs_pkg::OP_AVG_ADD: begin
        // an empty average takes the sample as it is
        st_d    = (st_q == '0) ? ft_q : avg_sum[8 +: drs_pkg::TimeW];
        since_d = (since_sum > (drs_pkg::CountW + 1)'(drs_pkg::COUNT_MAX)) ?
                  drs_pkg::COUNT_MAX : since_sum[drs_pkg::CountW-1:0];
      end
      drs_pkg::OP_DECIDE: begin
        if (!en_q) begin
          scale_d = hi;
        end else if (next_scale != scale_q) begin
          scale_d = next_scale;
          since_d = '0;
        end
      end
      drs_pkg::OP_W_MUL, drs_pkg::OP_H_MUL: acc_d = drs_pkg::AccW'(prod[drs_pkg::MulAW-1:0]);
      drs_pkg::OP_W_DIV: w_d = en_q ? clamp_dim(w_round) : clamp_dim(DimXW'(nw_q));
      drs_pkg::OP_H_DIV: h_d = en_q ? clamp_dim(h_round) : clamp_dim(DimXW'(nh_q));
      default: ;
    endcase
    // a target write reseeds the average
    if (cfg_we_i && cfg_addr_i == drs_pkg::REG_TARGET) begin
      st_d = cfg_data_i[drs_pkg::TimeW-1:0];
    end
  end

  // Configuration registers and item state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q       <= drs_pkg::ENABLE_RST;
      alpha_q    <= drs_pkg::ALPHA_RST;
      min_q      <= drs_pkg::MIN_RST;
      max_q      <= drs_pkg::MAX_RST;
      down_thr_q <= drs_pkg::DOWN_RST;
      up_thr_q   <= drs_pkg::UP_RST;
      cool_us_q  <= drs_pkg::COOL_RST;
      nw_q       <= drs_pkg::NATIVE_W_RST;
      nh_q       <= drs_pkg::NATIVE_H_RST;
      st_q       <= drs_pkg::TARGET_RST;
      scale_q    <= drs_pkg::MAX_RST;
      since_q    <= '0;
    end else begin
      st_q    <= st_d;
      scale_q <= scale_d;
      since_q <= since_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          drs_pkg::REG_ENABLE:   en_q    <= cfg_data_i[0];
          drs_pkg::REG_TARGET: begin
            down_thr_q <= drs_pkg::ThreshW'(cfg_data_i) * drs_pkg::DOWN_FACTOR;
            up_thr_q   <= drs_pkg::ThreshW'(cfg_data_i) * drs_pkg::UP_FACTOR;
          end
          drs_pkg::REG_ALPHA:    alpha_q <= cfg_data_i[drs_pkg::AlphaW-1:0];
          drs_pkg::REG_MIN:      min_q   <= cfg_data_i[drs_pkg::ScaleW-1:0];
          drs_pkg::REG_MAX:      max_q   <= cfg_data_i[drs_pkg::ScaleW-1:0];
          drs_pkg::REG_COOLDOWN: cool_us_q <= drs_pkg::CoolW'(cfg_data_i) * drs_pkg::US_PER_MS;
          drs_pkg::REG_NATIVE_W: nw_q    <= cfg_data_i[drs_pkg::DimW-1:0];
          drs_pkg::REG_NATIVE_H: nh_q    <= cfg_data_i[drs_pkg::DimW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    w_q   <= w_d;
    h_q   <= h_d;
    if (cmd_i.capture) begin
      ft_q <= frame_time_i;
      el_q <= elapsed_us_i;
    end
    if (cmd_i.load_out) begin
      res_scale_q <= scale_q;
      res_w_q     <= w_q;
      res_h_q     <= h_q;
      res_avg_q   <= st_q;
    end
  end

  assign scale_percent_o      = res_scale_q;
  assign render_width_o       = res_w_q;
  assign render_height_o      = res_h_q;
  assign average_frame_time_o = res_avg_q;

endmodule

/* rtl/core/dynamic_resolution_scaler_core.sv */
// Dynamic resolution scaler, top level: item channels, configuration port,
// controller and datapath. Depends on drs_pkg, drs_if, drs_ctrl, drs_datapath.
//
// One item per rendered frame carries the measured frame time (Q8.8 ms) and
// the microseconds since the previous frame; each item yields exactly one
// result with the render scale in percent, the render width and height, and
// the smoothed frame time; while scaling is enabled the width is a multiple
// of 16 and the height is even. The block works on one item at a time: an
// accepted item steps through the moving average, the scale decision, the
// width and the height and a finish step; the next item is taken in the cycle
// after the finish step. Averaging and sizing products go through one shared
// 21x22 multiplier; division by 100 is a multiply by a fixed reciprocal. The
// finished result sits in an output register, so a stalled consumer does not
// stop the next item from being accepted and worked on; it only holds the
// finish step until the register frees up. Configuration writes take effect
// at once and are meant for times when no item is in flight; writing the
// target also reloads the average. MaxDimension caps the render size before
// it is cut to 14 bits.
module dynamic_resolution_scaler_core #(
  parameter int unsigned MaxDimension = drs_pkg::DEFAULT_MAX_DIMENSION
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [drs_pkg::CfgIdxW-1:0]   cfg_addr_i,
  input  logic [drs_pkg::CfgDataW-1:0]  cfg_data_i,
  drs_in_if.sink                        item_i,
  drs_out_if.source                     result_o
);

  drs_pkg::drs_cmd_t cmd;
  logic              in_ready;
  logic              out_valid;

  // Sequence each item through the datapath steps
  drs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd)
  );

  // Hold configuration and state, run the arithmetic
  drs_datapath #(
    .MaxDimension (MaxDimension)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .cfg_we_i             (cfg_we_i),
    .cfg_addr_i           (cfg_addr_i),
    .cfg_data_i           (cfg_data_i),
    .frame_time_i         (item_i.frame_time),
    .elapsed_us_i         (item_i.elapsed_us),
    .scale_percent_o      (result_o.scale_percent),
    .render_width_o       (result_o.render_width),
    .render_height_o      (result_o.render_height),
    .average_frame_time_o (result_o.average_frame_time)
  );

  assign item_i.ready   = in_ready;
  assign result_o.valid = out_valid;

endmodule
